// ----- rtl/gsp_pkg.sv -----
// Shared types and constants for the GSM septet pack/unpack unit.
`default_nettype none

package gsp_pkg;

  // Widths of the message bit accumulator and its bit count.
  localparam int unsigned AccW = 14;
  localparam int unsigned CntW = 4;
  localparam int unsigned PhaseW = 3;

  // Septet index within a group of eight that may carry the terminator.
  localparam logic [PhaseW-1:0] LastPhase = 3'd7;

  // Results that one accepted item leaves for the output side.
  typedef struct packed {
    logic       two;    // A second result follows the first.
    logic [7:0] data0;
    logic [7:0] data1;
    logic       last;   // The final result of this entry ends the message.
  } gsp_entry_t;

endpackage : gsp_pkg

`default_nettype wire

// ----- rtl/gsp_front.sv -----
// Front end: holds the direction register and message state, and turns each item into results.
`default_nettype none

module gsp_front (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               cfg_write_i,
  input  wire               cfg_direction_i,
  input  wire               accept_i,
  input  wire  [7:0]        in_data_i,
  input  wire               in_last_i,
  output logic              push_o,
  output gsp_pkg::gsp_entry_t entry_o
);
  import gsp_pkg::*;

  typedef enum logic {
    DIR_PACK   = 1'b0,
    DIR_UNPACK = 1'b1
  } dir_e;

  dir_e              dir_q;
  logic [AccW-1:0]   acc_q, acc_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic              term_q, term_d;

  logic [AccW-1:0]   merged, rem1;
  logic [CntW-1:0]   sum, c1;
  logic [PhaseW-1:0] ph1;
  logic [6:0]        s0, s1;
  logic [1:0]        n;
  logic [7:0]        r0, r1;

  // Merge the item into the accumulator and extract the completed results.
  always_comb begin
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    phase_d = phase_q;
    term_d  = term_q;
    n       = 2'd0;
    r0      = 8'd0;
    r1      = 8'd0;
    s0      = 7'd0;
    s1      = 7'd0;
    rem1    = '0;
    c1      = '0;
    ph1     = phase_q + 3'd1;
    if (dir_q == DIR_PACK) begin
      merged = acc_q | (AccW'(in_data_i[6:0]) << cnt_q[2:0]);
      sum    = cnt_q + 4'd7;
    end else begin
      merged = acc_q | (AccW'(in_data_i) << cnt_q[2:0]);
      sum    = cnt_q + 4'd8;
    end

    if (dir_q == DIR_PACK) begin
      // One full octet at most, then a padded tail octet on the last item.
      if (sum >= 4'd8) begin
        r0    = merged[7:0];
        n     = 2'd1;
        acc_d = merged >> 8;
        cnt_d = sum - 4'd8;
      end else begin
        acc_d = merged;
        cnt_d = sum;
      end
      if (in_last_i && (cnt_d != '0)) begin
        if (n == 2'd0) begin
          r0 = acc_d[7:0];
        end else begin
          r1 = acc_d[7:0];
        end
        n = n + 2'd1;
      end
    end else if (!term_q) begin
      // Up to two septets; a zero eighth septet stops the message.
      s0      = merged[6:0];
      rem1    = merged >> 7;
      c1      = sum - 4'd7;
      acc_d   = rem1;
      cnt_d   = c1;
      phase_d = ph1;
      if ((phase_q == LastPhase) && (s0 == 7'd0)) begin
        term_d = 1'b1;
      end else begin
        r0 = {1'b0, s0};
        n  = 2'd1;
        if (c1 >= 4'd7) begin
          s1      = rem1[6:0];
          acc_d   = rem1 >> 7;
          cnt_d   = c1 - 4'd7;
          phase_d = ph1 + 3'd1;
          if ((ph1 == LastPhase) && (s1 == 7'd0)) begin
            term_d = 1'b1;
          end else begin
            r1 = {1'b0, s1};
            n  = 2'd2;
          end
        end
      end
    end

    // The end of a message returns the state to its start.
    if (in_last_i) begin
      acc_d   = '0;
      cnt_d   = '0;
      phase_d = '0;
      term_d  = 1'b0;
    end
  end

  assign push_o        = accept_i && (n != 2'd0);
  assign entry_o.two   = (n == 2'd2);
  assign entry_o.data0 = r0;
  assign entry_o.data1 = r1;
  assign entry_o.last  = in_last_i;

  // Direction register and message state; a direction write restarts the message.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q   <= DIR_PACK;
      acc_q   <= '0;
      cnt_q   <= '0;
      phase_q <= '0;
      term_q  <= 1'b0;
    end else if (cfg_write_i) begin
      dir_q   <= dir_e'(cfg_direction_i);
      acc_q   <= '0;
      cnt_q   <= '0;
      phase_q <= '0;
      term_q  <= 1'b0;
    end else if (accept_i) begin
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      phase_q <= phase_d;
      term_q  <= term_d;
    end
  end

  // Packing never holds a whole octet between items.
  a_pack_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dir_q == DIR_PACK) |-> (cnt_q <= 4'd7))
    else $error("pack bit count exceeds seven");

  // An open unpack message never holds a whole septet between items.
  a_unpack_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((dir_q == DIR_UNPACK) && !term_q) |-> (cnt_q <= 4'd6))
    else $error("unpack bit count holds a whole septet");

  // The terminator flag is only ever set while unpacking.
  a_term_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    term_q |-> (dir_q == DIR_UNPACK))
    else $error("terminated flag set while packing");

endmodule : gsp_front

`default_nettype wire

// ----- rtl/gsp_queue.sv -----
// Short queue of result entries between the front end and the output side.
`default_nettype none

module gsp_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  gsp_pkg::gsp_entry_t push_entry_i,
  output logic                full_o,
  input  wire                 pop_i,
  output logic                head_valid_o,
  output gsp_pkg::gsp_entry_t head_entry_o
);
  import gsp_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CountW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CountW-1:0] FullCount = CountW'(DEPTH);

  gsp_entry_t        mem_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CountW-1:0] count_q;
  logic              do_push, do_pop;

  assign full_o       = (count_q == FullCount);
  assign head_valid_o = (count_q != '0);
  assign head_entry_o = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // The front end is stalled whenever the queue is full.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into a full queue");

  // Pointers stay in step with the fill count.
  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with unequal pointers");

endmodule : gsp_queue

`default_nettype wire

// ----- rtl/gsp_back.sv -----
// Output side: sends the one or two results of each queued entry through an output register.
`default_nettype none

module gsp_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 head_valid_i,
  input  gsp_pkg::gsp_entry_t head_entry_i,
  output logic                pop_o,
  input  wire                 out_stall_i,
  output logic                out_valid_o,
  output logic [7:0]          out_data_o,
  output logic                out_last_o
);
  import gsp_pkg::*;

  logic       second_q;
  logic       out_valid_q;
  logic [7:0] out_data_q;
  logic       out_last_q;
  logic       load;

  // A new result enters the output register when it is empty or being taken.
  assign load  = head_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o = load && (second_q || !head_entry_i.two);

  // Result selection and sub-index state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      second_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        second_q    <= !second_q && head_entry_i.two;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      if (second_q) begin
        out_data_q <= head_entry_i.data1;
        out_last_q <= head_entry_i.last;
      end else begin
        out_data_q <= head_entry_i.data0;
        out_last_q <= head_entry_i.last && !head_entry_i.two;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

  // The second result is only pending while its entry is still at the head.
  a_second_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    second_q |-> (head_valid_i && head_entry_i.two))
    else $error("second result pending without a two-result entry");

endmodule : gsp_back

`default_nettype wire

// ----- rtl/gsm_septet_pack_unpack_unit.sv -----
// Top level of the GSM 7-bit default alphabet pack/unpack unit.
`default_nettype none

// The unit packs 7-bit characters into octets (direction 0) or unpacks octets
// into septets (direction 1), least significant bit first. It accepts one item
// per clock while its result queue has room, and delivers one result per clock
// from a registered output while the output is not stalled. Items giving one
// result or none therefore stream at one per cycle; an item giving two results
// (one unpacked octet in seven, or a last packed character with a tail octet)
// loads the output register twice, so long unpacking runs back up. The queue of
// QUEUE_DEPTH entries absorbs these bursts and output stalls. Write the
// direction only while the unit is idle; the write also restarts the message.
module gsm_septet_pack_unpack_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        cfg_valid_i,
  output logic       cfg_ready_o,
  input  wire        cfg_direction_i,
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  wire  [7:0] in_data_i,
  input  wire        in_last_i,
  output logic       out_valid_o,
  input  wire        out_stall_i,
  output logic [7:0] out_data_o,
  output logic       out_last_o
);
  import gsp_pkg::*;

  logic       accept;
  logic       push, full, pop, head_valid;
  gsp_entry_t push_entry, head_entry;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;
  assign accept      = in_valid_i && !full;

  gsp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_write_i    (cfg_valid_i && cfg_ready_o),
    .cfg_direction_i(cfg_direction_i),
    .accept_i       (accept),
    .in_data_i      (in_data_i),
    .in_last_i      (in_last_i),
    .push_o         (push),
    .entry_o        (push_entry)
  );

  gsp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_entry_i(push_entry),
    .full_o      (full),
    .pop_i       (pop),
    .head_valid_o(head_valid),
    .head_entry_o(head_entry)
  );

  gsp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_entry_i(head_entry),
    .pop_o       (pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_last_o  (out_last_o)
  );

endmodule : gsm_septet_pack_unpack_unit

`default_nettype wire

// ----- sim/gsp_checker.sv -----
// Checker for the GSM septet pack/unpack unit: predicts the coded stream and compares results.
module gsp_checker (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        cfg_valid_i,
  input  wire        cfg_ready_i,
  input  wire        cfg_direction_i,
  input  wire        in_valid_i,
  input  wire        in_stall_i,
  input  wire  [7:0] in_data_i,
  input  wire        in_last_i,
  input  wire        out_valid_i,
  input  wire        out_stall_i,
  input  wire  [7:0] out_data_i,
  input  wire        out_last_i,
  input  wire        drained_i,
  output int         due_count_o,
  output int         fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import gsp_pkg::*;

  // One coded byte as it should leave the unit.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } coded_byte_t;

  coded_byte_t coded_due[$];

  // Mirror of the unit's message state and direction register.
  logic              unpack_mode;
  logic [AccW-1:0]   bit_acc;
  logic [CntW-1:0]   bit_cnt;
  logic [PhaseW-1:0] septet_idx;
  logic              msg_terminated;
  logic              leftover_checked = 1'b0;

  initial begin
    fail_count_o = 0;
    due_count_o = 0;
  end

  // Print one line per mismatch and count it.
  task automatic flag_error(input string what);
    $display("[%0t] checker: %s", $time, what);
    fail_count_o++;
  endtask

  function automatic void restart_message();
    bit_acc = '0;
    bit_cnt = '0;
    septet_idx = '0;
    msg_terminated = 1'b0;
  endfunction

  // Advance the message state by one request and queue the coded bytes it yields.
  function automatic void code_request(input logic [7:0] data, input logic last);
    logic [15:0]  merged;
    logic [6:0]   septet;
    coded_byte_t  res [2];
    int           n;
    n = 0;
    res[0] = '0;
    res[1] = '0;
    if (!unpack_mode) begin
      // Packing: append seven bits, emit a full octet, flush the tail on the last one.
      merged = {2'b00, bit_acc} | (16'(data[6:0]) << bit_cnt[2:0]);
      bit_acc = merged[AccW-1:0];
      bit_cnt = bit_cnt + 4'd7;
      if (bit_cnt >= 4'd8) begin
        res[n] = '{data: bit_acc[7:0], last: 1'b0};
        n++;
        bit_acc = bit_acc >> 8;
        bit_cnt = bit_cnt - 4'd8;
      end
      if (last && bit_cnt != 0) begin
        res[n] = '{data: bit_acc[7:0], last: 1'b0};
        n++;
      end
    end else if (!msg_terminated) begin
      // Unpacking: append an octet and drain whole septets until a terminator.
      merged = {2'b00, bit_acc} | (16'(data) << bit_cnt[2:0]);
      bit_acc = merged[AccW-1:0];
      bit_cnt = bit_cnt + 4'd8;
      while (bit_cnt >= 4'd7 && !msg_terminated) begin
        septet = bit_acc[6:0];
        bit_acc = bit_acc >> 7;
        bit_cnt = bit_cnt - 4'd7;
        if (septet_idx == LastPhase && septet == 7'd0) begin
          msg_terminated = 1'b1;
        end else begin
          res[n] = '{data: {1'b0, septet}, last: 1'b0};
          n++;
        end
        septet_idx = septet_idx + 3'd1;
      end
    end
    if (last) begin
      if (n > 0) res[n-1].last = 1'b1;
      restart_message();
    end
    for (int i = 0; i < n; i++) coded_due.push_back(res[i]);
  endfunction

  // Watch all three channels on each edge; compare results before predicting new ones.
  always @(posedge clk_i or negedge rst_ni) begin
    coded_byte_t exp_byte;
    if (!rst_ni) begin
      unpack_mode = 1'b0;
      restart_message();
      coded_due.delete();
      due_count_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (coded_due.size() == 0) begin
          flag_error($sformatf("result 0x%02h last=%0b with nothing expected",
                               out_data_i, out_last_i));
        end else begin
          exp_byte = coded_due.pop_front();
          if (out_data_i !== exp_byte.data)
            flag_error($sformatf("out_data 0x%02h, expected 0x%02h", out_data_i,
                                 exp_byte.data));
          if (out_last_i !== exp_byte.last)
            flag_error($sformatf("out_last %0b, expected %0b (data 0x%02h)", out_last_i,
                                 exp_byte.last, exp_byte.data));
        end
      end
      if (in_valid_i && !in_stall_i) code_request(in_data_i, in_last_i);
      if (cfg_valid_i && cfg_ready_i) begin
        unpack_mode = cfg_direction_i;
        restart_message();
      end
      if (drained_i && !leftover_checked) begin
        leftover_checked = 1'b1;
        if (coded_due.size() != 0)
          flag_error($sformatf("%0d expected results never arrived", coded_due.size()));
      end
      due_count_o <= coded_due.size();
    end
  end

endmodule

// ----- sim/tb_top.sv -----
// Testbench top for the GSM septet pack/unpack unit: stimulus, output stalls and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PhaseItems = 115;
  localparam int SettleCycles = 10;
  localparam int DrainCycles = 5000;

  // Receiver stall patterns.
  localparam int StallNone = 0;
  localparam int StallLight = 1;
  localparam int StallHeavy = 2;
  localparam int StallPeriodic = 3;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_direction = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_data = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_data;
  logic       out_last;
  logic       drained = 1'b0;
  int         due_count;
  int         fail_count;

  int burst_left = 0;
  int stall_mode = StallNone;
  int stall_left = 0;
  int stall_tick = 0;

  always #2 clk = ~clk;

  gsm_septet_pack_unpack_unit DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_direction_i(cfg_direction),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .in_data_i      (in_data),
    .in_last_i      (in_last),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .out_data_o     (out_data),
    .out_last_o     (out_last)
  );

  gsp_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_direction_i(cfg_direction),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .in_data_i      (in_data),
    .in_last_i      (in_last),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .out_data_i     (out_data),
    .out_last_i     (out_last),
    .drained_i      (drained),
    .due_count_o    (due_count),
    .fail_count_o   (fail_count)
  );

  // Reset starts asserted and is released once, never asserted again.
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  // The receiver switches at random between stall patterns.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(StallNone, StallPeriodic);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      StallLight:    out_stall <= ($urandom_range(0, 3) == 0);
      StallHeavy:    out_stall <= ($urandom_range(0, 3) != 0);
      StallPeriodic: out_stall <= (stall_tick % 5 < 2);
      default:       out_stall <= 1'b0;
    endcase
  end

  // Offer one request and return at the edge that accepts it; gaps fall between bursts.
  task automatic send_item(input logic [7:0] data, input logic last);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 120)
                                                : $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    in_data <= data;
    in_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
  endtask

  // Let the unit go idle, then write the direction register.
  task automatic write_direction(input logic dir);
    in_valid <= 1'b0;
    do @(posedge clk); while (due_count != 0);
    repeat (SettleCycles) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_direction <= dir;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // A phase of random messages; the phase usually ends in the middle of one.
  task automatic run_random_phase(input logic unpack);
    int         msg_len;
    int         pos;
    logic [7:0] data;
    pos = 0;
    msg_len = 1;
    for (int i = 0; i < PhaseItems; i++) begin
      if (pos == 0)
        msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      data = 8'($urandom_range(0, 255));
      // Septet eight of each group sits in bits 7:1 of octet seven; zero it often.
      if (unpack && pos % 7 == 6 && $urandom_range(0, 2) == 0)
        data = 8'($urandom_range(0, 1));
      send_item(data, pos == msg_len - 1);
      pos = (pos == msg_len - 1) ? 0 : pos + 1;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);

    // Packing from the reset direction: field extremes, ignored bit 7, tail octet.
    send_item(8'h00, 1'b0);
    send_item(8'h7F, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h80, 1'b1);
    // Eight characters fill seven octets exactly, so the last one leaves no tail.
    for (int i = 0; i < 8; i++) send_item(8'h41 + 8'(i), i == 7);
    send_item(8'h01, 1'b1);

    // Unpacking: a zero eighth septet terminates, later octets are ignored,
    // and the last item then yields nothing.
    write_direction(1'b1);
    for (int i = 0; i < 7; i++) send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b1);
    // Messages of one or two octets leave fill bits that are dropped.
    send_item(8'hFF, 1'b1);
    send_item(8'h80, 1'b0);
    send_item(8'h7F, 1'b1);

    // Random phases alternating the direction, with a repeated write.
    write_direction(1'b0);
    for (int ph = 0; ph < 6; ph++) begin
      write_direction(ph[0]);
      run_random_phase(ph[0]);
    end

    // Drain, allow stray results to show up, then settle the verdict.
    in_valid <= 1'b0;
    for (int k = 0; k < DrainCycles && due_count != 0; k++) @(posedge clk);
    repeat (20) @(posedge clk);
    drained <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #1_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
